@@ rtl/rea_pkg.sv @@
// rea_pkg: shared types, constants and the half-step decode table for the
// rotary encoder acceleration decoder. Depends on nothing.
package rea_pkg;

	localparam int COUNT_WIDTH = 16;
	localparam int TIME_W = 32;
	localparam int SPEED_W = 8;
	localparam int ACCEL_W = 7;
	localparam int CODE_W = 6;
	localparam int OUT_W = 16;
	localparam int PADDR_W = 5;
	localparam int PDATA_W = 32;

	localparam logic [CODE_W-1:0] CODE_CCW = 6'h10;
	localparam logic [CODE_W-1:0] CODE_CW = 6'h20;
	localparam logic [ACCEL_W-1:0] ACCEL_MAX = 7'd99;

	localparam int US_PER_MS = 1000;
	// quotients at or past this size already pin the level to a clamp limit
	localparam int Q_LIMIT = 99 + 2 * 255 + 1;
	localparam int Q_W = 10;
	localparam int DIFF_LIMIT = Q_LIMIT * US_PER_MS;
	localparam int MAG_W = 20;
	// floor(x / 1000) == (x * RECIP) >> RECIP_SHIFT for x below 2**MAG_W
	localparam int RECIP_SHIFT = 30;
	localparam int RECIP_W = 21;
	localparam logic [RECIP_W-1:0] RECIP = 21'd1073742;

	localparam logic [TIME_W-1:0] CLICK_MIN_RST = 32'd5000;
	localparam logic [TIME_W-1:0] CLICK_MAX_RST = 32'd1000000;

	typedef enum logic [1:0] {
		CMD_ROT  = 2'd0,
		CMD_SW   = 2'd1,
		CMD_READ = 2'd2,
		CMD_NOP  = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		REG_ACCEL_EN  = 3'd0,
		REG_SPEED_DN  = 3'd1,
		REG_SPEED_UP  = 3'd2,
		REG_CLICK_MIN = 3'd3,
		REG_CLICK_MAX = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [1:0]        command;
		logic              pin_a;
		logic              pin_b;
		logic              switch_level;
		logic [TIME_W-1:0] time_us;
	} item_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] step_total;
		logic                    clicked;
	} result_t;

	typedef struct packed {
		logic               accel_enable;
		logic [SPEED_W-1:0] speed_down;
		logic [SPEED_W-1:0] speed_up;
		logic [TIME_W-1:0]  click_min_us;
		logic [TIME_W-1:0]  click_max_us;
		logic               accel_clr;
	} cfg_t;

	localparam logic [CODE_W-1:0] QUAD_TBL [6][4] = '{
		'{6'h03, 6'h02, 6'h01, 6'h00},
		'{6'h23, 6'h00, 6'h01, 6'h00},
		'{6'h13, 6'h02, 6'h00, 6'h00},
		'{6'h03, 6'h05, 6'h04, 6'h00},
		'{6'h03, 6'h03, 6'h04, 6'h10},
		'{6'h03, 6'h05, 6'h03, 6'h20}
	};

	function automatic logic [CODE_W-1:0] quad_next(
		input logic [CODE_W-1:0] code,
		input logic [1:0]        pins
	);
		logic [3:0] idx;
		idx = code[3:0];
		if (idx > 4'd5) begin
			idx = 4'd0;
		end
		return QUAD_TBL[idx[2:0]][pins];
	endfunction

endpackage

@@ rtl/rea_cfg.sv @@
// rea_cfg: APB register file for the encoder decoder settings.
// Depends on rea_pkg.
module rea_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [rea_pkg::PADDR_W-1:0]   paddr,
	input  logic [rea_pkg::PDATA_W-1:0]   pwdata,
	output logic [rea_pkg::PDATA_W-1:0]   prdata,
	output rea_pkg::cfg_t                 cfg
);

	logic                           en_q;
	logic [rea_pkg::SPEED_W-1:0]    speed_dn_q;
	logic [rea_pkg::SPEED_W-1:0]    speed_up_q;
	logic [rea_pkg::TIME_W-1:0]     click_min_q;
	logic [rea_pkg::TIME_W-1:0]     click_max_q;
	logic                           clr_q;
	logic                           wr;
	rea_pkg::reg_idx_t              idx;

	assign wr = psel && penable && pwrite;
	assign idx = rea_pkg::reg_idx_t'(paddr[rea_pkg::PADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q <= 1'b1;
			speed_dn_q <= '0;
			speed_up_q <= '0;
			click_min_q <= rea_pkg::CLICK_MIN_RST;
			click_max_q <= rea_pkg::CLICK_MAX_RST;
			clr_q <= 1'b0;
		end else begin
			clr_q <= 1'b0;
			if (wr) begin
				case (idx)
					rea_pkg::REG_ACCEL_EN: begin
						// acceleration restarts only on an actual change
						if (pwdata[0] != en_q) begin
							en_q <= pwdata[0];
							clr_q <= 1'b1;
						end
					end
					rea_pkg::REG_SPEED_DN: speed_dn_q <= pwdata[rea_pkg::SPEED_W-1:0];
					rea_pkg::REG_SPEED_UP: speed_up_q <= pwdata[rea_pkg::SPEED_W-1:0];
					rea_pkg::REG_CLICK_MIN: click_min_q <= pwdata;
					rea_pkg::REG_CLICK_MAX: click_max_q <= pwdata;
					default: ;
				endcase
			end
		end
	end

	always_comb begin
		case (idx)
			rea_pkg::REG_ACCEL_EN: prdata = {{(rea_pkg::PDATA_W-1){1'b0}}, en_q};
			rea_pkg::REG_SPEED_DN:
				prdata = {{(rea_pkg::PDATA_W-rea_pkg::SPEED_W){1'b0}}, speed_dn_q};
			rea_pkg::REG_SPEED_UP:
				prdata = {{(rea_pkg::PDATA_W-rea_pkg::SPEED_W){1'b0}}, speed_up_q};
			rea_pkg::REG_CLICK_MIN: prdata = click_min_q;
			rea_pkg::REG_CLICK_MAX: prdata = click_max_q;
			default: prdata = '0;
		endcase
	end

	assign cfg.accel_enable = en_q;
	assign cfg.speed_down = speed_dn_q;
	assign cfg.speed_up = speed_up_q;
	assign cfg.click_min_us = click_min_q;
	assign cfg.click_max_us = click_max_q;
	assign cfg.accel_clr = clr_q;

endmodule

@@ rtl/rea_rot.sv @@
// rea_rot: half-step quadrature decode, acceleration update and the saturating
// step count. Depends on rea_pkg.
module rea_rot #(
	parameter int COUNT_WIDTH = rea_pkg::COUNT_WIDTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  rea_pkg::cfg_t                     cfg,
	input  logic                              fire,
	input  rea_pkg::item_t                    item,
	output logic signed [rea_pkg::OUT_W-1:0]  step_total
);

	localparam int EXT_W = (COUNT_WIDTH > rea_pkg::OUT_W) ? COUNT_WIDTH : rea_pkg::OUT_W;

	logic [rea_pkg::CODE_W-1:0]        code_q;
	logic [rea_pkg::ACCEL_W-1:0]       accel_q;
	logic signed [COUNT_WIDTH-1:0]     accum_q;
	logic [rea_pkg::TIME_W-1:0]        last_q;

	logic                              is_rot;
	logic                              is_read;
	logic [rea_pkg::CODE_W-1:0]        code_next;
	logic                              cw;
	logic                              step;
	logic [rea_pkg::TIME_W-1:0]        diff;
	logic [rea_pkg::TIME_W-1:0]        mag;
	logic                              big;
	logic [rea_pkg::MAG_W+rea_pkg::RECIP_W-1:0] prod;
	logic [rea_pkg::Q_W-1:0]           qm;
	logic [rea_pkg::SPEED_W-1:0]       speed;
	logic signed [11:0]                acc_sum;
	logic [rea_pkg::ACCEL_W-1:0]       acc_clamp;
	logic [rea_pkg::ACCEL_W-1:0]       accel_new;
	logic [7:0]                        amt;
	logic signed [COUNT_WIDTH:0]       delta;
	logic signed [COUNT_WIDTH:0]       sum;
	logic signed [COUNT_WIDTH-1:0]     accum_new;
	logic signed [EXT_W-1:0]           accum_ext;

	assign is_rot = fire && (item.command == rea_pkg::CMD_ROT);
	assign is_read = fire && (item.command == rea_pkg::CMD_READ);

	assign code_next = rea_pkg::quad_next(code_q, {item.pin_b, item.pin_a});
	assign cw = (code_next == rea_pkg::CODE_CW);
	assign step = cw || (code_next == rea_pkg::CODE_CCW);

	// elapsed time in whole ms, truncated toward zero, magnitude clamped
	assign diff = item.time_us - last_q;
	assign mag = diff[rea_pkg::TIME_W-1] ? (~diff + 32'd1) : diff;
	assign big = (mag >= rea_pkg::TIME_W'(rea_pkg::DIFF_LIMIT));
	assign prod = mag[rea_pkg::MAG_W-1:0] * rea_pkg::RECIP;
	assign qm = big ? rea_pkg::Q_W'(rea_pkg::Q_LIMIT) : prod[rea_pkg::RECIP_SHIFT +: rea_pkg::Q_W];
	assign speed = cw ? cfg.speed_up : cfg.speed_down;

	always_comb begin
		acc_sum = 12'(accel_q) + 12'({speed, 1'b0})
			+ (diff[rea_pkg::TIME_W-1] ? 12'(qm) : -12'(qm));
		if (acc_sum[11]) begin
			acc_clamp = '0;
		end else if (acc_sum > 12'sd99) begin
			acc_clamp = rea_pkg::ACCEL_MAX;
		end else begin
			acc_clamp = acc_sum[rea_pkg::ACCEL_W-1:0];
		end
	end

	assign accel_new = cfg.accel_enable ? acc_clamp : '0;
	assign amt = {1'b0, accel_new} + 8'd1;
	assign delta = cw ? $signed({{(COUNT_WIDTH-7){1'b0}}, amt})
		: -$signed({{(COUNT_WIDTH-7){1'b0}}, amt});
	assign sum = {accum_q[COUNT_WIDTH-1], accum_q} + delta;

	// saturate at the signed count range
	always_comb begin
		if (sum[COUNT_WIDTH] != sum[COUNT_WIDTH-1]) begin
			accum_new = sum[COUNT_WIDTH] ? {1'b1, {(COUNT_WIDTH-1){1'b0}}}
				: {1'b0, {(COUNT_WIDTH-1){1'b1}}};
		end else begin
			accum_new = sum[COUNT_WIDTH-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_q <= '0;
			accel_q <= '0;
			accum_q <= '0;
			last_q <= '0;
		end else begin
			if (is_rot) begin
				code_q <= code_next;
				if (step) begin
					accel_q <= accel_new;
					accum_q <= accum_new;
					last_q <= item.time_us;
				end
			end else if (is_read) begin
				accum_q <= '0;
			end
			if (cfg.accel_clr) begin
				accel_q <= '0;
			end
		end
	end

	assign accum_ext = EXT_W'(accum_q);
	assign step_total = accum_ext[rea_pkg::OUT_W-1:0];

	a_accel_range: assert property (@(posedge clk) disable iff (!arst_n)
		accel_q <= rea_pkg::ACCEL_MAX)
		else $error("acceleration level above limit");

	a_read_clears: assert property (@(posedge clk) disable iff (!arst_n)
		is_read |=> (accum_q == '0))
		else $error("step count not cleared by read");

	a_disabled_no_accel: assert property (@(posedge clk) disable iff (!arst_n)
		(is_rot && step && !cfg.accel_enable) |=> (accel_q == '0))
		else $error("acceleration left set while disabled");

endmodule

@@ rtl/rea_click.sv @@
// rea_click: push switch press timing and click flag.
// Depends on rea_pkg.
module rea_click (
	input  logic           clk,
	input  logic           arst_n,
	input  rea_pkg::cfg_t  cfg,
	input  logic           fire,
	input  rea_pkg::item_t item,
	output logic           click_pending
);

	logic [rea_pkg::TIME_W-1:0] press_q;
	logic                       pend_q;
	logic [rea_pkg::TIME_W-1:0] dur;
	logic                       hit;

	// a negative duration never qualifies
	assign dur = item.time_us - press_q;
	assign hit = !dur[rea_pkg::TIME_W-1] && (dur > cfg.click_min_us)
		&& (dur < cfg.click_max_us);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			press_q <= '0;
			pend_q <= 1'b0;
		end else if (fire) begin
			if (item.command == rea_pkg::CMD_SW) begin
				if (!item.switch_level) begin
					press_q <= item.time_us;
				end else if ((press_q != '0) && hit) begin
					pend_q <= 1'b1;
				end
			end else if (item.command == rea_pkg::CMD_READ) begin
				pend_q <= 1'b0;
			end
		end
	end

	assign click_pending = pend_q;

endmodule

@@ rtl/rotary_encoder_accel_decoder_top.sv @@
// Rotary encoder decoder with step acceleration and switch click detection.
// Takes one event item per cycle: an input register holds the item,
// combinational logic (a single 20x21 multiply for the ms conversion) updates
// state and a result register holds the read-out. Accepts a new item every
// clock; only a read command that meets a stalled, still full result register
// holds the input stage. A read result is loaded into the result register
// when the read fires. Depends on rea_pkg, rea_cfg, rea_rot and rea_click.
module rotary_encoder_accel_decoder_top #(
	parameter int COUNT_WIDTH = rea_pkg::COUNT_WIDTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         item_valid,
	output logic                         item_stall,
	input  rea_pkg::item_t               item,
	output logic                         result_valid,
	input  logic                         result_stall,
	output rea_pkg::result_t             result,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [rea_pkg::PADDR_W-1:0]  paddr,
	input  logic [rea_pkg::PDATA_W-1:0]  pwdata,
	output logic [rea_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready
);

	rea_pkg::cfg_t                     cfg;
	rea_pkg::item_t                    item_s1;
	logic                              valid_s1;
	logic                              read_s1;
	logic                              block_s1;
	logic                              fire_s1;
	logic                              res_valid_q;
	rea_pkg::result_t                  res_q;
	logic signed [rea_pkg::OUT_W-1:0]  step_total;
	logic                              click_pending;

	assign pready = 1'b1;

	rea_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	assign read_s1 = (item_s1.command == rea_pkg::CMD_READ);
	assign block_s1 = read_s1 && res_valid_q && result_stall;
	assign fire_s1 = valid_s1 && !block_s1;
	assign item_stall = valid_s1 && block_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_valid && !item_stall) begin
			valid_s1 <= 1'b1;
		end else if (fire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
	end

	rea_rot #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_rot (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.fire       (fire_s1),
		.item       (item_s1),
		.step_total (step_total)
	);

	rea_click u_click (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.fire          (fire_s1),
		.item          (item_s1),
		.click_pending (click_pending)
	);

	// result register, refilled in the same cycle its transfer completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (fire_s1 && read_s1) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && read_s1) begin
			res_q.step_total <= step_total;
			res_q.clicked <= click_pending;
		end
	end

	assign result_valid = res_valid_q;
	assign result = res_q;

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> (valid_s1 && read_s1 && res_valid_q))
		else $error("input stalled without a pending read");

	a_read_result: assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && read_s1) |=> (res_valid_q && !res_q.clicked == !$past(click_pending)))
		else $error("read did not load the result register");

	a_click_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && read_s1) |=> !click_pending)
		else $error("click flag not cleared by read");

endmodule
